@@ src/psbs_pkg.sv @@
// shared types, codes and constants of the prefix sum bucket search unit
package psbs_pkg;

  localparam int DEFAULT_MAX_ENTRIES = 1024;
  localparam int SEG_W    = 32;
  localparam int SUM_W    = 42;
  localparam int BUCKET_W = 11;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_STORED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ANSWERED = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [SEG_W-1:0] segment_length;
    logic [SUM_W-1:0] target;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BUCKET_W-1:0] bucket_index;
  } out_item_t;

  typedef enum logic {
    SRCH_IDLE,
    SRCH_RUN
  } srch_state_t;

endpackage

@@ src/prefix_sum_bucket_search_unit.sv @@
// top level of the prefix sum bucket search unit
//
// in_data carries one item per transfer. a load (operation 0) appends
// segment_length to the running total, stores the new prefix sum and
// answers status 0, or status 1 without change when the table is full.
// a query (operation 1) returns the smallest index i in 0..N whose prefix
// sum is at least target (index 0 is the implicit zero sum), or N+1.
// one result per item, in order, on out_data.
// a load result is in the output register in the cycle after its
// transfer. a query is accepted, then runs one table read and compare
// per cycle in a read-then-compare loop on the single table read port;
// its result is registered in the output when the search ends. one item
// is worked on at a time; in_stall stays high while a query searches.
// reset clears the entry count, the running total and the output valid;
// table contents are left as they are and only written rows are used in compares.
// when out_stall holds a result, the next item waits on in_stall until
// that result has transferred.
module prefix_sum_bucket_search_unit import psbs_pkg::*; #(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = $clog2(MAX_ENTRIES + 2);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic              in_fire, out_fire;
  logic              table_full;
  logic              wr_en;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic              query_start;
  logic [ADDR_W-1:0] rd_addr;
  logic [SUM_W-1:0]  rd_data;
  logic              srch_busy, srch_done;
  logic [IDX_W-1:0]  srch_index;
  logic [IDX_W+BUCKET_W-1:0] index_ext;

  // the output slot is free once its result transfers in the same cycle
  assign in_stall  = srch_busy || (out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;

  assign table_full  = (count_r == CNT_W'(MAX_ENTRIES));
  assign wr_en       = in_fire && (in_data.operation == OP_LOAD) && !table_full;
  assign query_start = in_fire && (in_data.operation == OP_QUERY);

  // running total saturates at all ones so the table stays sorted
  assign sum_ext = {1'b0, total_r} + (SUM_W + 1)'(in_data.segment_length);
  assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  // index masked or zero-extended to the result field width
  assign index_ext = {{BUCKET_W{1'b0}}, srch_index};

  always_comb begin
    count_nxt     = count_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && in_data.operation == OP_LOAD) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.status       = table_full ? STATUS_FULL : STATUS_STORED;
      out_data_nxt.bucket_index = '0;
    end
    if (wr_en) begin
      count_nxt = count_r + 1'b1;
      total_nxt = sum_sat;
    end
    // slot is always empty by the time a search finishes
    if (srch_done) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.status       = STATUS_ANSWERED;
      out_data_nxt.bucket_index = index_ext[BUCKET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  psbs_table #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (sum_sat),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  psbs_search #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (query_start),
    .count_i  (count_r),
    .target_i (in_data.target),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .busy     (srch_busy),
    .done     (srch_done),
    .index    (srch_index)
  );

endmodule

@@ src/psbs_table.sv @@
// prefix sum table: one write port, one registered read port
module psbs_table import psbs_pkg::*; #(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [SUM_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [SUM_W-1:0]  rd_data
);

  logic [SUM_W-1:0] mem [MAX_ENTRIES];
  logic [SUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/psbs_search.sv @@
// lower-bound binary search sequencer over the prefix sum table
module psbs_search import psbs_pkg::*; #(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1),
  localparam int IDX_W  = $clog2(MAX_ENTRIES + 2)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [SUM_W-1:0]  target_i,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [SUM_W-1:0]  rd_data,
  output logic              busy,
  output logic              done,
  output logic [IDX_W-1:0]  index
);

  srch_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] mid_r, mid_nxt;
  logic [SUM_W-1:0] tgt_r;
  logic [SUM_W-1:0] sum_at_mid;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] addr_wide;

  // index zero is the implicit zero sum
  assign sum_at_mid = (mid_r == '0) ? '0 : rd_data;

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    done      = 1'b0;
    case (state_r)
      SRCH_IDLE: begin
        if (start) begin
          lo_nxt    = '0;
          hi_nxt    = IDX_W'(count_i) + 1'b1;
          state_nxt = SRCH_RUN;
        end
      end
      SRCH_RUN: begin
        if (sum_at_mid < tgt_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        if (lo_nxt >= hi_nxt) begin
          done      = 1'b1;
          state_nxt = SRCH_IDLE;
        end
      end
      default: begin
        state_nxt = SRCH_IDLE;
      end
    endcase
    mid_sum   = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    mid_nxt   = mid_sum[IDX_W:1];
    addr_wide = mid_nxt - 1'b1;
  end

  // table row of index mid is mid-1; read issued in the cycle before the compare
  assign rd_addr = addr_wide[ADDR_W-1:0];
  assign busy    = (state_r == SRCH_RUN);
  assign index   = lo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SRCH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    if (start && state_r == SRCH_IDLE) begin
      tgt_r <= target_i;
    end
  end

endmodule
